[hw/rtl/rvdec_pkg.sv]
// ----------------------------------------------------------------------------
// rvdec_pkg
// Types and encodings shared by the rv32im instruction decoder and its users.
// ----------------------------------------------------------------------------
package rvdec_pkg;

	// major opcodes
	localparam logic [6:0] OP_LOAD   = 7'h03;
	localparam logic [6:0] OP_STORE  = 7'h23;
	localparam logic [6:0] OP_ALU    = 7'h33;
	localparam logic [6:0] OP_ALUI   = 7'h13;
	localparam logic [6:0] OP_BRANCH = 7'h63;
	localparam logic [6:0] OP_JAL    = 7'h6F;
	localparam logic [6:0] OP_JALR   = 7'h67;
	localparam logic [6:0] OP_LUI    = 7'h37;
	localparam logic [6:0] OP_AUIPC  = 7'h17;
	localparam logic [6:0] OP_SYSTEM = 7'h73;

	// funct7 values
	localparam logic [6:0] F7_BASE = 7'h00;
	localparam logic [6:0] F7_ALT  = 7'h20;
	localparam logic [6:0] F7_MUL  = 7'h01;

	// funct3 values used for decisions
	localparam logic [2:0] F3_ADD = 3'd0;
	localparam logic [2:0] F3_SLL = 3'd1;
	localparam logic [2:0] F3_SR  = 3'd5;

	// instruction class
	localparam logic [3:0] CLS_LOAD    = 4'd0;
	localparam logic [3:0] CLS_STORE   = 4'd1;
	localparam logic [3:0] CLS_ALU_REG = 4'd2;
	localparam logic [3:0] CLS_ALU_IMM = 4'd3;
	localparam logic [3:0] CLS_BRANCH  = 4'd4;
	localparam logic [3:0] CLS_JAL     = 4'd5;
	localparam logic [3:0] CLS_JALR    = 4'd6;
	localparam logic [3:0] CLS_LUI     = 4'd7;
	localparam logic [3:0] CLS_AUIPC   = 4'd8;
	localparam logic [3:0] CLS_SYSTEM  = 4'd9;
	localparam logic [3:0] CLS_UNKNOWN = 4'd10;

	// instruction format
	localparam logic [2:0] FMT_R = 3'd0;
	localparam logic [2:0] FMT_I = 3'd1;
	localparam logic [2:0] FMT_S = 3'd2;
	localparam logic [2:0] FMT_B = 3'd3;
	localparam logic [2:0] FMT_U = 3'd4;
	localparam logic [2:0] FMT_J = 3'd5;

	// memory access width
	localparam logic [1:0] ACC_BYTE = 2'd0;
	localparam logic [1:0] ACC_HALF = 2'd1;
	localparam logic [1:0] ACC_WORD = 2'd2;

	// alu operations
	localparam logic [4:0] ALU_ADD    = 5'd0;
	localparam logic [4:0] ALU_SUB    = 5'd1;
	localparam logic [4:0] ALU_SLL    = 5'd2;
	localparam logic [4:0] ALU_SLT    = 5'd3;
	localparam logic [4:0] ALU_SLTU   = 5'd4;
	localparam logic [4:0] ALU_XOR    = 5'd5;
	localparam logic [4:0] ALU_SRL    = 5'd6;
	localparam logic [4:0] ALU_SRA    = 5'd7;
	localparam logic [4:0] ALU_OR     = 5'd8;
	localparam logic [4:0] ALU_AND    = 5'd9;
	localparam logic [4:0] ALU_MUL    = 5'd10;
	localparam logic [4:0] ALU_MULH   = 5'd11;
	localparam logic [4:0] ALU_MULHSU = 5'd12;
	localparam logic [4:0] ALU_MULHU  = 5'd13;
	localparam logic [4:0] ALU_DIV    = 5'd14;
	localparam logic [4:0] ALU_DIVU   = 5'd15;
	localparam logic [4:0] ALU_REM    = 5'd16;
	localparam logic [4:0] ALU_REMU   = 5'd17;

	// branch conditions
	localparam logic [2:0] BR_EQ  = 3'd0;
	localparam logic [2:0] BR_NE  = 3'd1;
	localparam logic [2:0] BR_LT  = 3'd2;
	localparam logic [2:0] BR_GE  = 3'd3;
	localparam logic [2:0] BR_LTU = 3'd4;
	localparam logic [2:0] BR_GEU = 3'd5;

	typedef struct packed {
		logic [31:0] instruction_word;
		logic        decode_en;
	} dec_cmd_t;

	typedef struct packed {
		logic [4:0]         dest_register;
		logic [4:0]         source_register_a;
		logic [4:0]         source_register_b;
		logic [2:0]         minor_function;
		logic [6:0]         major_function;
		logic [6:0]         opcode_field;
		logic signed [31:0] immediate_value;
		logic [3:0]         instruction_class;
		logic [2:0]         format_code;
		logic [1:0]         access_width;
		logic [4:0]         alu_func;
		logic [2:0]         branch_cond;
	} dec_result_t;

endpackage

[hw/rtl/rv32im_instruction_decoder.sv]
// ----------------------------------------------------------------------------
// rv32im_instruction_decoder
// Splits an rv32im instruction into fields, immediate, class, format and
// alu / memory / branch controls, two register stages deep.
// ----------------------------------------------------------------------------
//
//  channel   handshake          payload
//  -------   ----------------   -------------------------
//  command   start / busy       cmd    (dec_cmd_t)
//  result    done (strobe)      result (dec_result_t)
//
//  a command beat is taken at every edge where start is high; busy stays low
//  one beat per cycle; the result strobe comes after the command has passed
//  the input register, decode logic and result register
//  a beat with decode_en low is taken and produces no result
//  reset clears the valid flags only; the receiver cannot stall
//
module rv32im_instruction_decoder (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  rvdec_pkg::dec_cmd_t    cmd,
	output logic                   done,
	output rvdec_pkg::dec_result_t result
);
	import rvdec_pkg::*;

	logic        valid_s1;
	logic [31:0] word_s1;
	logic        valid_s2;
	dec_result_t result_s2;
	dec_result_t dec;

	logic [6:0]  op;
	logic [2:0]  f3;
	logic [6:0]  f7;
	logic [31:0] imm_i, imm_s, imm_b, imm_u, imm_j;
	logic [1:0]  acc_w;
	logic [4:0]  alu_reg, alu_imm;
	logic [2:0]  br_cond;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy && cmd.decode_en;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			word_s1 <= cmd.instruction_word;
		end
		if (valid_s1) begin
			result_s2 <= dec;
		end
	end

	assign op = word_s1[6:0];
	assign f3 = word_s1[14:12];
	assign f7 = word_s1[31:25];

	assign imm_i = {{20{word_s1[31]}}, word_s1[31:20]};
	assign imm_s = {{20{word_s1[31]}}, word_s1[31:25], word_s1[11:7]};
	assign imm_b = {{19{word_s1[31]}}, word_s1[31], word_s1[7], word_s1[30:25],
		word_s1[11:8], 1'b0};
	assign imm_u = {word_s1[31:12], 12'b0};
	assign imm_j = {{11{word_s1[31]}}, word_s1[31], word_s1[19:12], word_s1[20],
		word_s1[30:21], 1'b0};

	// funct3 above word still means word
	always_comb begin
		case (f3)
			3'd0:    acc_w = ACC_BYTE;
			3'd1:    acc_w = ACC_HALF;
			default: acc_w = ACC_WORD;
		endcase
	end

	always_comb begin
		case (f3)
			3'd0:    br_cond = BR_EQ;
			3'd1:    br_cond = BR_NE;
			3'd4:    br_cond = BR_LT;
			3'd5:    br_cond = BR_GE;
			3'd6:    br_cond = BR_LTU;
			3'd7:    br_cond = BR_GEU;
			default: br_cond = BR_EQ;
		endcase
	end

	// base rv32i operation by funct3; also used for the immediate form
	function automatic logic [4:0] base_op(input logic [2:0] fn3);
		logic [4:0] r;
		case (fn3)
			3'd0:    r = ALU_ADD;
			3'd1:    r = ALU_SLL;
			3'd2:    r = ALU_SLT;
			3'd3:    r = ALU_SLTU;
			3'd4:    r = ALU_XOR;
			3'd5:    r = ALU_SRL;
			3'd6:    r = ALU_OR;
			default: r = ALU_AND;
		endcase
		return r;
	endfunction

	always_comb begin
		case (f7)
			F7_BASE: alu_reg = base_op(f3);
			F7_ALT: begin
				if (f3 == F3_ADD) begin
					alu_reg = ALU_SUB;
				end else if (f3 == F3_SR) begin
					alu_reg = ALU_SRA;
				end else begin
					alu_reg = ALU_ADD;
				end
			end
			F7_MUL:  alu_reg = ALU_MUL + {2'b00, f3};
			default: alu_reg = ALU_ADD;
		endcase
	end

	// funct7 only matters for immediate shifts
	always_comb begin
		if (f3 == F3_SLL) begin
			alu_imm = (f7 == F7_BASE) ? ALU_SLL : ALU_ADD;
		end else if (f3 == F3_SR) begin
			if (f7 == F7_BASE) begin
				alu_imm = ALU_SRL;
			end else if (f7 == F7_ALT) begin
				alu_imm = ALU_SRA;
			end else begin
				alu_imm = ALU_ADD;
			end
		end else begin
			alu_imm = base_op(f3);
		end
	end

	always_comb begin
		dec.dest_register     = word_s1[11:7];
		dec.source_register_a = word_s1[19:15];
		dec.source_register_b = word_s1[24:20];
		dec.minor_function    = f3;
		dec.major_function    = f7;
		dec.opcode_field      = op;
		dec.access_width      = ACC_BYTE;
		dec.alu_func          = ALU_ADD;
		dec.branch_cond       = BR_EQ;
		case (op)
			OP_LOAD: begin
				dec.instruction_class = CLS_LOAD;
				dec.format_code       = FMT_I;
				dec.immediate_value   = imm_i;
				dec.access_width      = acc_w;
			end
			OP_STORE: begin
				dec.instruction_class = CLS_STORE;
				dec.format_code       = FMT_S;
				dec.immediate_value   = imm_s;
				dec.access_width      = acc_w;
			end
			OP_ALU: begin
				dec.instruction_class = CLS_ALU_REG;
				dec.format_code       = FMT_R;
				dec.immediate_value   = '0;
				dec.alu_func          = alu_reg;
			end
			OP_ALUI: begin
				dec.instruction_class = CLS_ALU_IMM;
				dec.format_code       = FMT_I;
				dec.immediate_value   = imm_i;
				dec.alu_func          = alu_imm;
			end
			OP_BRANCH: begin
				dec.instruction_class = CLS_BRANCH;
				dec.format_code       = FMT_B;
				dec.immediate_value   = imm_b;
				dec.branch_cond       = br_cond;
			end
			OP_JAL: begin
				dec.instruction_class = CLS_JAL;
				dec.format_code       = FMT_J;
				dec.immediate_value   = imm_j;
			end
			OP_JALR: begin
				dec.instruction_class = CLS_JALR;
				dec.format_code       = FMT_I;
				dec.immediate_value   = imm_i;
			end
			OP_LUI: begin
				dec.instruction_class = CLS_LUI;
				dec.format_code       = FMT_U;
				dec.immediate_value   = imm_u;
			end
			OP_AUIPC: begin
				dec.instruction_class = CLS_AUIPC;
				dec.format_code       = FMT_U;
				dec.immediate_value   = imm_u;
			end
			OP_SYSTEM: begin
				dec.instruction_class = CLS_SYSTEM;
				dec.format_code       = FMT_I;
				dec.immediate_value   = imm_i;
			end
			default: begin
				dec.instruction_class = CLS_UNKNOWN;
				dec.format_code       = FMT_I;
				dec.immediate_value   = imm_i;
			end
		endcase
	end

	assign done   = valid_s2;
	assign result = result_s2;

`ifndef SYNTH
	// an enabled beat shows up on done after the input and result registers
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && cmd.decode_en |=> ##1 done)
		else $error("enabled command beat produced no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(valid_s1))
		else $error("result strobe without a decoded beat");

	a_rfmt_imm: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.format_code == FMT_R |-> result.immediate_value == 0)
		else $error("register format with nonzero immediate");

	a_branch_only: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.instruction_class != CLS_BRANCH |->
		result.branch_cond == BR_EQ)
		else $error("branch condition set outside a branch");

	a_mem_only: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.instruction_class != CLS_LOAD &&
		result.instruction_class != CLS_STORE |-> result.access_width == ACC_BYTE)
		else $error("access width set outside a load or store");
`endif

endmodule

[test/tb_rv32im_instruction_decoder.sv]
// ----------------------------------------------------------------------------
// tb_rv32im_instruction_decoder
// Drives instruction beats through the start / busy port, predicts each
// decode in the testbench and compares every result field on each strobe.
// ----------------------------------------------------------------------------
module tb_rv32im_instruction_decoder;

	import rvdec_pkg::*;

	localparam int STALL_LIMIT   = 2000;
	localparam int DRAIN_CYCLES  = 8;
	localparam int RANDOM_BEATS  = 600;

	// funct3 encodings not in the package
	localparam logic [2:0] F3_SLT  = 3'd2;
	localparam logic [2:0] F3_SLTU = 3'd3;
	localparam logic [2:0] F3_XOR  = 3'd4;
	localparam logic [2:0] F3_OR   = 3'd6;
	localparam logic [2:0] F3_AND  = 3'd7;

	localparam logic [2:0] F3_LB  = 3'd0;
	localparam logic [2:0] F3_LH  = 3'd1;
	localparam logic [2:0] F3_LW  = 3'd2;
	localparam logic [2:0] F3_LBU = 3'd4;
	localparam logic [2:0] F3_LHU = 3'd5;

	localparam logic [2:0] F3_BEQ      = 3'd0;
	localparam logic [2:0] F3_BNE      = 3'd1;
	localparam logic [2:0] F3_BR_RSVD  = 3'd2;
	localparam logic [2:0] F3_BLT      = 3'd4;
	localparam logic [2:0] F3_BGE      = 3'd5;
	localparam logic [2:0] F3_BLTU     = 3'd6;
	localparam logic [2:0] F3_BGEU     = 3'd7;

	logic        clk    = 1'b0;
	logic        arst_n = 1'b0;
	logic        start  = 1'b0;
	logic        busy;
	dec_cmd_t    cmd    = '0;
	logic        done;
	dec_result_t result;

	dec_result_t expected_decodes[$];
	dec_result_t oldest_decode;
	int          error_count = 0;
	int          stall_cycles = 0;

	rv32im_instruction_decoder uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.result (result)
	);

	always #5 clk = ~clk;

	function automatic logic [31:0] make_word(input logic [6:0] f7, input logic [4:0] rs2,
			input logic [4:0] rs1, input logic [2:0] f3, input logic [4:0] rd,
			input logic [6:0] op);
		return {f7, rs2, rs1, f3, rd, op};
	endfunction

	function automatic logic [4:0] alu_op_for(input logic [6:0] f7, input logic [2:0] f3,
			input logic is_imm);
		logic [4:0] base_op;
		case (f3)
			F3_ADD:  base_op = ALU_ADD;
			F3_SLL:  base_op = ALU_SLL;
			F3_SLT:  base_op = ALU_SLT;
			F3_SLTU: base_op = ALU_SLTU;
			F3_XOR:  base_op = ALU_XOR;
			F3_SR:   base_op = ALU_SRL;
			F3_OR:   base_op = ALU_OR;
			default: base_op = ALU_AND;
		endcase
		if (is_imm) begin
			// funct7 only matters for the shifts
			if (f3 == F3_SLL)
				return (f7 == F7_BASE) ? ALU_SLL : ALU_ADD;
			if (f3 == F3_SR) begin
				if (f7 == F7_BASE)
					return ALU_SRL;
				return (f7 == F7_ALT) ? ALU_SRA : ALU_ADD;
			end
			return base_op;
		end
		if (f7 == F7_BASE)
			return base_op;
		if (f7 == F7_ALT) begin
			if (f3 == F3_ADD)
				return ALU_SUB;
			return (f3 == F3_SR) ? ALU_SRA : ALU_ADD;
		end
		if (f7 == F7_MUL)
			return ALU_MUL + 5'(f3);
		return ALU_ADD;
	endfunction

	function automatic logic [1:0] access_width_for(input logic [2:0] f3);
		case (f3)
			F3_LB:   return ACC_BYTE;
			F3_LH:   return ACC_HALF;
			default: return ACC_WORD;
		endcase
	endfunction

	function automatic dec_result_t predict_decode(input logic [31:0] w);
		dec_result_t r;
		logic [31:0] imm_i, imm_s, imm_b, imm_u, imm_j;
		imm_i = {{20{w[31]}}, w[31:20]};
		imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
		imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
		imm_u = {w[31:12], 12'b0};
		imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};

		r = '0;
		r.dest_register     = w[11:7];
		r.source_register_a = w[19:15];
		r.source_register_b = w[24:20];
		r.minor_function    = w[14:12];
		r.major_function    = w[31:25];
		r.opcode_field      = w[6:0];
		r.access_width      = ACC_BYTE;
		r.alu_func          = ALU_ADD;
		r.branch_cond       = BR_EQ;
		r.format_code       = FMT_I;
		r.immediate_value   = imm_i;

		case (w[6:0])
			OP_LOAD: begin
				r.instruction_class = CLS_LOAD;
				r.access_width      = access_width_for(w[14:12]);
			end
			OP_STORE: begin
				r.instruction_class = CLS_STORE;
				r.format_code       = FMT_S;
				r.immediate_value   = imm_s;
				r.access_width      = access_width_for(w[14:12]);
			end
			OP_ALU: begin
				r.instruction_class = CLS_ALU_REG;
				r.format_code       = FMT_R;
				r.immediate_value   = '0;
				r.alu_func          = alu_op_for(w[31:25], w[14:12], 1'b0);
			end
			OP_ALUI: begin
				r.instruction_class = CLS_ALU_IMM;
				r.alu_func          = alu_op_for(w[31:25], w[14:12], 1'b1);
			end
			OP_BRANCH: begin
				r.instruction_class = CLS_BRANCH;
				r.format_code       = FMT_B;
				r.immediate_value   = imm_b;
				case (w[14:12])
					F3_BEQ:  r.branch_cond = BR_EQ;
					F3_BNE:  r.branch_cond = BR_NE;
					F3_BLT:  r.branch_cond = BR_LT;
					F3_BGE:  r.branch_cond = BR_GE;
					F3_BLTU: r.branch_cond = BR_LTU;
					F3_BGEU: r.branch_cond = BR_GEU;
					default: r.branch_cond = BR_EQ;
				endcase
			end
			OP_JAL: begin
				r.instruction_class = CLS_JAL;
				r.format_code       = FMT_J;
				r.immediate_value   = imm_j;
			end
			OP_JALR:   r.instruction_class = CLS_JALR;
			OP_LUI: begin
				r.instruction_class = CLS_LUI;
				r.format_code       = FMT_U;
				r.immediate_value   = imm_u;
			end
			OP_AUIPC: begin
				r.instruction_class = CLS_AUIPC;
				r.format_code       = FMT_U;
				r.immediate_value   = imm_u;
			end
			OP_SYSTEM: r.instruction_class = CLS_SYSTEM;
			default:   r.instruction_class = CLS_UNKNOWN;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		error_count++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %h expected %h", name, got, want));
	endtask

	// start stays high from one beat to the next; only idling lowers it
	task automatic send_instruction(input logic [31:0] w, input logic en);
		dec_cmd_t c;
		c.instruction_word = w;
		c.decode_en        = en;
		start <= 1'b1;
		cmd   <= c;
		do @(posedge clk); while (busy !== 1'b0);
		if (en)
			expected_decodes.push_back(predict_decode(w));
	endtask

	task automatic idle_cycles(input int n);
		dec_cmd_t junk;
		junk.instruction_word = $urandom;
		junk.decode_en        = 1'b1;
		start <= 1'b0;
		cmd   <= junk;
		repeat (n) @(posedge clk);
	endtask

	function automatic int gap_length();
		if ($urandom_range(0, 15) == 0)
			return $urandom_range(10, 40);
		return $urandom_range(1, 3);
	endfunction

	function automatic logic [31:0] random_instruction();
		logic [31:0] w;
		w = $urandom;
		if ($urandom_range(0, 99) < 12)
			return w;
		case ($urandom_range(0, 9))
			0: w[6:0] = OP_LOAD;
			1: w[6:0] = OP_STORE;
			2: w[6:0] = OP_ALU;
			3: w[6:0] = OP_ALUI;
			4: w[6:0] = OP_BRANCH;
			5: w[6:0] = OP_JAL;
			6: w[6:0] = OP_JALR;
			7: w[6:0] = OP_LUI;
			8: w[6:0] = OP_AUIPC;
			default: w[6:0] = OP_SYSTEM;
		endcase
		// steer alu encodings toward the funct7 values that name operations
		if ((w[6:0] == OP_ALU || w[6:0] == OP_ALUI) && $urandom_range(0, 3) != 0) begin
			case ($urandom_range(0, 2))
				0: w[31:25] = F7_BASE;
				1: w[31:25] = F7_ALT;
				default: w[31:25] = F7_MUL;
			endcase
		end
		return w;
	endfunction

	task automatic test_field_extremes();
		send_instruction(32'h0000_0000, 1'b1);
		send_instruction(32'hFFFF_FFFF, 1'b1);
		send_instruction(32'hFFFF_FFFF, 1'b0);
		send_instruction(make_word(7'h7F, 5'h1F, 5'h1F, F3_AND, 5'h1F, 7'h0B), 1'b1);
	endtask

	task automatic test_instruction_classes();
		send_instruction(make_word(7'h40, 5'd0, 5'd0, F3_LW, 5'd31, OP_LOAD), 1'b1);
		send_instruction(make_word(7'h7F, 5'd31, 5'd1, F3_LB, 5'd31, OP_STORE), 1'b1);
		send_instruction({20'hFFFFF, 5'd5, OP_LUI}, 1'b1);
		send_instruction({20'h80000, 5'd0, OP_AUIPC}, 1'b1);
		send_instruction({1'b1, 10'd0, 1'b0, 8'd0, 5'd1, OP_JAL}, 1'b1);
		send_instruction({1'b0, 10'h3FF, 1'b1, 8'hFF, 5'd0, OP_JAL}, 1'b1);
		send_instruction(make_word(7'h3F, 5'h1F, 5'd2, F3_ADD, 5'd1, OP_JALR), 1'b1);
		send_instruction(make_word(F7_BASE, 5'd1, 5'd0, F3_ADD, 5'd0, OP_SYSTEM), 1'b1);
	endtask

	task automatic test_memory_widths();
		send_instruction(make_word(7'h00, 5'd3, 5'd4, F3_LH, 5'd5, OP_LOAD), 1'b1);
		send_instruction(make_word(7'h3F, 5'd3, 5'd4, F3_LBU, 5'd5, OP_LOAD), 1'b1);
		send_instruction(make_word(7'h40, 5'd3, 5'd4, F3_LHU, 5'd0, OP_STORE), 1'b1);
	endtask

	task automatic test_alu_encodings();
		send_instruction(make_word(F7_ALT, 5'd2, 5'd3, F3_ADD, 5'd4, OP_ALU), 1'b1);
		send_instruction(make_word(F7_ALT, 5'd2, 5'd3, F3_SR, 5'd4, OP_ALU), 1'b1);
		send_instruction(make_word(F7_MUL, 5'd2, 5'd3, F3_ADD, 5'd4, OP_ALU), 1'b1);
		send_instruction(make_word(F7_MUL, 5'd2, 5'd3, F3_AND, 5'd4, OP_ALU), 1'b1);
		// funct7 / funct3 pairs with no operation fall back to add; immediate forms ignore funct7 except for shifts
		send_instruction(make_word(7'h7F, 5'd2, 5'd3, F3_ADD, 5'd4, OP_ALU), 1'b1);
		send_instruction(make_word(F7_ALT, 5'd2, 5'd3, F3_SLTU, 5'd4, OP_ALU), 1'b1);
		send_instruction(make_word(F7_BASE, 5'd9, 5'd3, F3_SLL, 5'd4, OP_ALUI), 1'b1);
		send_instruction(make_word(F7_ALT, 5'd9, 5'd3, F3_SLL, 5'd4, OP_ALUI), 1'b1);
		send_instruction(make_word(F7_ALT, 5'd9, 5'd3, F3_SR, 5'd4, OP_ALUI), 1'b1);
		send_instruction(make_word(F7_MUL, 5'd9, 5'd3, F3_SR, 5'd4, OP_ALUI), 1'b1);
		send_instruction(make_word(7'h7F, 5'd9, 5'd3, F3_XOR, 5'd4, OP_ALUI), 1'b1);
	endtask

	task automatic test_branch_conditions();
		send_instruction(make_word(7'h40, 5'd6, 5'd7, F3_BGEU, 5'd0, OP_BRANCH), 1'b1);
		send_instruction(make_word(7'h3F, 5'd6, 5'd7, F3_BNE, 5'h1F, OP_BRANCH), 1'b1);
		send_instruction(make_word(7'h55, 5'd6, 5'd7, F3_BR_RSVD, 5'h0A, OP_BRANCH), 1'b1);
	endtask

	task automatic test_random_stream();
		bit no_idle;
		no_idle = 1'b0;
		for (int i = 0; i < RANDOM_BEATS; i++) begin
			if (i % 50 == 0)
				no_idle = ($urandom_range(0, 2) == 0);
			send_instruction(random_instruction(), $urandom_range(0, 9) != 0);
			if (!no_idle && $urandom_range(0, 2) == 0)
				idle_cycles(gap_length());
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && done === 1'b1) begin
			if (expected_decodes.size() == 0) begin
				report_mismatch($sformatf("result with nothing expected, opcode %h",
					result.opcode_field));
			end else begin
				oldest_decode = expected_decodes.pop_front();
				check_field("dest_register", 32'(result.dest_register),
					32'(oldest_decode.dest_register));
				check_field("source_register_a", 32'(result.source_register_a),
					32'(oldest_decode.source_register_a));
				check_field("source_register_b", 32'(result.source_register_b),
					32'(oldest_decode.source_register_b));
				check_field("minor_function", 32'(result.minor_function),
					32'(oldest_decode.minor_function));
				check_field("major_function", 32'(result.major_function),
					32'(oldest_decode.major_function));
				check_field("opcode_field", 32'(result.opcode_field),
					32'(oldest_decode.opcode_field));
				check_field("immediate_value", result.immediate_value,
					oldest_decode.immediate_value);
				check_field("instruction_class", 32'(result.instruction_class),
					32'(oldest_decode.instruction_class));
				check_field("format_code", 32'(result.format_code),
					32'(oldest_decode.format_code));
				check_field("access_width", 32'(result.access_width),
					32'(oldest_decode.access_width));
				check_field("alu_func", 32'(result.alu_func),
					32'(oldest_decode.alu_func));
				check_field("branch_cond", 32'(result.branch_cond),
					32'(oldest_decode.branch_cond));
			end
		end
	end

	// counts cycles with no command beat and no result beat
	always @(posedge clk) begin
		if (!arst_n || (start && busy === 1'b0) || done === 1'b1)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("rv32im_instruction_decoder verification failed");
			$finish;
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_field_extremes();
		test_instruction_classes();
		test_memory_widths();
		test_alu_encodings();
		test_branch_conditions();
		test_random_stream();

		start <= 1'b0;
		while (expected_decodes.size() != 0)
			@(posedge clk);
		// a late or stray strobe would still land in this window
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("rv32im_instruction_decoder verification clean");
		else
			$display("rv32im_instruction_decoder verification failed");
		$finish;
	end

endmodule
